/* sv/lsp_pkg.sv */
package lsp_pkg;

    // Block configuration.
    localparam int CHANNELS  = 6;
    localparam int ADC_BITS  = 10;

    // Field and register widths.
    localparam int WEIGHT_W  = 16;
    localparam int FRAC_BITS = 8;
    localparam int THR_W     = 10;
    localparam int POS_W     = 8;
    localparam int CFG_IDX_W = $clog2(CHANNELS + 1);
    localparam int CFG_DATA_W = WEIGHT_W;
    localparam int CH_W      = $clog2(CHANNELS);

    // Normalized readings run from 0 to NORM_FULL.
    localparam int NORM_FULL = 100;
    localparam int N_W       = $clog2(NORM_FULL + 1);
    localparam int NORM_NUM_W = ADC_BITS + N_W;
    localparam int SUM_W     = $clog2(NORM_FULL * CHANNELS + 1);
    localparam int CMP_W     = (SUM_W > THR_W) ? SUM_W : THR_W;
    localparam int PROD_W    = WEIGHT_W + N_W + 1;
    localparam int WSUM_W    = PROD_W + $clog2(CHANNELS);

    // Shared divider operand widths. The quotient never needs to exceed
    // NORM_FULL, so it has N_W bits and saturates to all ones when it would not fit.
    localparam int QUOT_W    = N_W;
    localparam int DIV_NUM_W = WSUM_W + N_W;
    localparam int DIV_DEN_W = SUM_W + FRAC_BITS;

    // Position limits.
    localparam int POS_LIMIT = 100;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_CH0    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_THRESHOLD = CFG_IDX_W'(CHANNELS);

    localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(100);

    // Item kinds.
    localparam logic KIND_CALIBRATE = 1'b0;
    localparam logic KIND_MEASURE   = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [ADC_BITS-1:0] sample0;
        logic [ADC_BITS-1:0] sample1;
        logic [ADC_BITS-1:0] sample2;
        logic [ADC_BITS-1:0] sample3;
        logic [ADC_BITS-1:0] sample4;
        logic [ADC_BITS-1:0] sample5;
    } sensor_t;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic                    on_line;
    } result_t;

    typedef struct packed {
        logic capture;
        logic setup;
        logic div_start;
        logic take_n;
        logic mul;
        logic acc;
        logic fin_setup;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic last_ch;
        logic online;
        logic out_free;
    } dp_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CH_SETUP,
        S_CH_DIV,
        S_CH_WAIT,
        S_CH_MUL,
        S_CH_ACC,
        S_FIN_SETUP,
        S_FIN_DIV,
        S_FIN_WAIT,
        S_DONE
    } ctrl_state_t;

    // Reset weights: a symmetric spread from -2.5 to +2.5 in Q8.8.
    function automatic logic signed [WEIGHT_W-1:0] weight_reset(input int ch);
        logic signed [WEIGHT_W-1:0] w;
        case (ch)
            0:       w = -16'sd640;
            1:       w = -16'sd384;
            2:       w = -16'sd128;
            3:       w = 16'sd128;
            4:       w = 16'sd384;
            5:       w = 16'sd640;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

/* sv/lsp_div.sv */
module lsp_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [lsp_pkg::DIV_NUM_W-1:0]   dividend,
    input  logic [lsp_pkg::DIV_DEN_W-1:0]   divisor,
    output logic                            done,
    output logic [lsp_pkg::QUOT_W-1:0]      quotient
);
    import lsp_pkg::*;

    localparam int STEP_W = $clog2(QUOT_W);

    logic [DIV_NUM_W-1:0] rem_reg;
    logic [DIV_NUM_W-1:0] dsh_reg;
    logic [QUOT_W-1:0]    q_reg;
    logic [STEP_W-1:0]    step_reg;
    logic                 run_reg;
    logic                 done_reg;
    logic                 sat_reg;
    logic                 sat_next;

    // A quotient that would not fit saturates to all ones.
    assign sat_next = dividend >= (DIV_NUM_W'(divisor) << QUOT_W);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (run_reg && step_reg == '0)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b1;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= dividend;
            dsh_reg  <= DIV_NUM_W'(divisor) << (QUOT_W - 1);
            sat_reg  <= sat_next;
            q_reg    <= '0;
            step_reg <= STEP_W'(QUOT_W - 1);
        end
        else if (run_reg)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
                q_reg   <= {q_reg[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                q_reg   <= {q_reg[QUOT_W-2:0], 1'b0};
            end
            dsh_reg  <= dsh_reg >> 1;
            step_reg <= step_reg - STEP_W'(1);
        end
    end

    assign done     = done_reg;
    assign quotient = sat_reg ? '1 : q_reg;

endmodule

/* sv/lsp_ctrl.sv */
module lsp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sensor_valid,
    input  logic                 sensor_kind,
    output logic                 sensor_stall,
    input  lsp_pkg::dp_status_t  status,
    output lsp_pkg::dp_cmd_t     cmd
);
    import lsp_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        sensor_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                sensor_stall = 1'b0;
                if (sensor_valid)
                begin
                    cmd.capture = 1'b1;
                    if (sensor_kind == KIND_MEASURE)
                    begin
                        state_next = S_CH_SETUP;
                    end
                end
            end
            S_CH_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_CH_DIV;
            end
            S_CH_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_CH_WAIT;
            end
            S_CH_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.take_n = 1'b1;
                    state_next = S_CH_MUL;
                end
            end
            S_CH_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_CH_ACC;
            end
            S_CH_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = status.last_ch ? S_FIN_SETUP : S_CH_SETUP;
            end
            S_FIN_SETUP:
            begin
                cmd.fin_setup = 1'b1;
                state_next    = status.online ? S_FIN_DIV : S_DONE;
            end
            S_FIN_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_FIN_WAIT;
            end
            S_FIN_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* sv/lsp_datapath.sv */
module lsp_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lsp_pkg::sensor_t                  sensor,
    input  logic                              cfg_en,
    input  logic [lsp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lsp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  lsp_pkg::dp_cmd_t                  cmd,
    output lsp_pkg::dp_status_t               status,
    output logic                              result_valid,
    input  logic                              result_stall,
    output lsp_pkg::result_t                  result
);
    import lsp_pkg::*;

    logic signed [WEIGHT_W-1:0] weight_reg [CHANNELS];
    logic [THR_W-1:0]           thr_reg;
    logic [ADC_BITS-1:0]        min_reg [CHANNELS];
    logic [ADC_BITS-1:0]        max_reg [CHANNELS];
    logic [ADC_BITS-1:0]        samp_reg [CHANNELS];
    logic [ADC_BITS-1:0]        in_samp [CHANNELS];
    logic signed [POS_W-1:0]    last_pos_reg;

    logic [CH_W-1:0]            ch_reg;
    logic                       span_ok_reg;
    logic [N_W-1:0]             n_reg;
    logic [SUM_W-1:0]           sum_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [WSUM_W-1:0]   wsum_reg;
    logic                       online_reg;
    logic                       neg_reg;
    logic [DIV_NUM_W-1:0]       div_num_reg;
    logic [DIV_DEN_W-1:0]       div_den_reg;
    logic                       result_valid_reg;
    result_t                    result_reg;

    logic                       div_done;
    logic [QUOT_W-1:0]          div_q;

    logic [ADC_BITS-1:0]        lo;
    logic [ADC_BITS-1:0]        hi;
    logic [ADC_BITS-1:0]        x_up;
    logic [ADC_BITS-1:0]        x_clamp;
    logic                       span_ok;
    logic [NORM_NUM_W-1:0]      norm_num;
    logic signed [PROD_W-1:0]   prod_next;
    logic [WSUM_W-1:0]          wsum_mag;
    logic [DIV_NUM_W-1:0]       mag_ext;
    logic                       online;
    logic                       out_free;
    logic [QUOT_W-1:0]          q_clamp;
    logic signed [POS_W-1:0]    q_pos;
    logic signed [POS_W-1:0]    pos_next;

    assign in_samp[0] = sensor.sample0;
    assign in_samp[1] = sensor.sample1;
    assign in_samp[2] = sensor.sample2;
    assign in_samp[3] = sensor.sample3;
    assign in_samp[4] = sensor.sample4;
    assign in_samp[5] = sensor.sample5;

    // Configuration registers and calibrated ranges.
    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_ch
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                weight_reg[i] <= weight_reset(i);
                min_reg[i]    <= '1;
                max_reg[i]    <= '0;
            end
            else
            begin
                if (cfg_en && cfg_index == CFG_WEIGHT_CH0 + CFG_IDX_W'(i))
                begin
                    weight_reg[i] <= $signed(cfg_data[WEIGHT_W-1:0]);
                end
                if (cmd.capture && sensor.kind == KIND_CALIBRATE)
                begin
                    if (in_samp[i] < min_reg[i])
                    begin
                        min_reg[i] <= in_samp[i];
                    end
                    if (in_samp[i] > max_reg[i])
                    begin
                        max_reg[i] <= in_samp[i];
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (cmd.capture)
            begin
                samp_reg[i] <= in_samp[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESHOLD_RESET;
        end
        else if (cfg_en && cfg_index == CFG_LINE_THRESHOLD)
        begin
            thr_reg <= cfg_data[THR_W-1:0];
        end
    end

    // Per-channel normalization operands.
    assign lo       = min_reg[ch_reg];
    assign hi       = max_reg[ch_reg];
    assign x_up     = (samp_reg[ch_reg] < lo) ? lo : samp_reg[ch_reg];
    assign x_clamp  = (x_up > hi) ? hi : x_up;
    assign span_ok  = hi > lo;
    assign norm_num = NORM_NUM_W'(x_clamp - lo) * NORM_NUM_W'(NORM_FULL);

    assign prod_next = weight_reg[ch_reg] * $signed({1'b0, n_reg});

    // Magnitude of the weighted sum, later scaled by 100 with shifts and adds.
    assign wsum_mag = wsum_reg[WSUM_W-1] ? WSUM_W'(-wsum_reg) : WSUM_W'(wsum_reg);
    assign mag_ext  = DIV_NUM_W'(wsum_mag);
    assign online   = CMP_W'(sum_reg) > CMP_W'(thr_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ch_reg   <= '0;
            sum_reg  <= '0;
            wsum_reg <= '0;
        end
        if (cmd.setup)
        begin
            span_ok_reg <= span_ok;
            div_num_reg <= span_ok ? DIV_NUM_W'(norm_num) : '0;
            div_den_reg <= span_ok ? DIV_DEN_W'(hi - lo) : DIV_DEN_W'(1);
        end
        if (cmd.take_n)
        begin
            n_reg <= span_ok_reg ? (N_W'(NORM_FULL) - N_W'(div_q)) : '0;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
            sum_reg  <= sum_reg + SUM_W'(n_reg);
        end
        if (cmd.acc)
        begin
            wsum_reg <= wsum_reg + WSUM_W'(prod_reg);
            ch_reg   <= ch_reg + CH_W'(1);
        end
        if (cmd.fin_setup)
        begin
            online_reg  <= online;
            neg_reg     <= wsum_reg[WSUM_W-1];
            div_num_reg <= (mag_ext << 6) + (mag_ext << 5) + (mag_ext << 2);
            div_den_reg <= DIV_DEN_W'({sum_reg, {FRAC_BITS{1'b0}}});
        end
    end

    lsp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_num_reg),
        .divisor  (div_den_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Final position.
    assign q_clamp = (div_q > QUOT_W'(POS_LIMIT)) ? QUOT_W'(POS_LIMIT) : div_q;
    assign q_pos   = $signed(POS_W'(q_clamp));

    always_comb
    begin
        if (online_reg)
        begin
            pos_next = neg_reg ? -q_pos : q_pos;
        end
        else if (last_pos_reg < 0)
        begin
            pos_next = -POS_W'(POS_LIMIT);
        end
        else
        begin
            pos_next = POS_W'(POS_LIMIT);
        end
    end

    assign out_free = !result_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            last_pos_reg     <= '0;
        end
        else if (cmd.emit)
        begin
            result_valid_reg <= 1'b1;
            last_pos_reg     <= pos_next;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_reg.position <= pos_next;
            result_reg.on_line  <= online_reg;
        end
    end

    assign status.div_done = div_done;
    assign status.last_ch  = ch_reg == CH_W'(CHANNELS - 1);
    assign status.online   = online;
    assign status.out_free = out_free;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* sv/line_sensor_position_estimator_core.sv */
// Line sensor position estimator. Each item on the sensor channel carries six
// raw ADC readings and a kind bit. A calibration item widens every channel's
// minimum and maximum, is taken in the idle state and gives no result. A measure
// item maps each reading inversely onto 0..100 within its calibrated range,
// forms the weighted centroid with the signed Q8.8 weights and reports a
// position of -100..+100 with an on-line flag; when the normalized sum does
// not exceed the line threshold the position jumps to the extreme on the side
// of the last reported position. All seven divisions of a measure item share
// one restoring divider that yields one quotient bit per cycle, and the block
// stalls the sensor channel until the measure item is done; the final division
// is skipped when the line is lost. A finished result sits in an output
// register, so the next item is accepted while it waits to be taken.
// Configuration registers are written through cfg_en, cfg_index and cfg_data;
// the user must write them only while the block is idle, as the block itself
// does not enforce this.
module line_sensor_position_estimator_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sensor_valid,
    output logic                              sensor_stall,
    input  lsp_pkg::sensor_t                  sensor,
    output logic                              result_valid,
    input  logic                              result_stall,
    output lsp_pkg::result_t                  result,
    input  logic                              cfg_en,
    input  logic [lsp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lsp_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import lsp_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // The controller sequences the channels through the shared divider and
    // multiplier; the datapath holds every register that carries data.
    lsp_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sensor_valid (sensor_valid),
        .sensor_kind  (sensor.kind),
        .sensor_stall (sensor_stall),
        .status       (status),
        .cmd          (cmd)
    );

    lsp_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .sensor       (sensor),
        .cfg_en       (cfg_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
